### src/cbte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbte_pkg
// Shared types and constants of the cubic B-spline trajectory evaluator:
// transaction payloads, command codes, register indexes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cbte_pkg;

   // Default depth of the control point store
   localparam int MAX_POINTS_DEF = 64;

   // Configuration port
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CSR_IW-1:0] CSR_KNOT_SPAN     = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_INV_SPAN      = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_INV_SPAN_SQ   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DURATION      = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_HOLD          = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_USE_POINT_Z   = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_DEFAULT_Z     = 3'd6;

   // Input commands
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_EVAL   = 2'd2;

   // Weight classes (position, velocity, acceleration)
   localparam logic [1:0] CLS_POS = 2'd0;
   localparam logic [1:0] CLS_VEL = 2'd1;
   localparam logic [1:0] CLS_ACC = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] elapsed_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
   } rsp_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_CDUR, ST_TIME, ST_TAU, ST_SEG, ST_U2, ST_U3, ST_WGT,
      ST_READ, ST_MAC, ST_DLOAD, ST_DSTEP, ST_PSTORE, ST_VSTORE, ST_ALOAD,
      ST_SCHI, ST_SCLO, ST_SRND, ST_ZERO, ST_OUT
   } state_type;

   // Datapath operations
   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_CDUR, OP_TIME, OP_TAU, OP_SEG, OP_U2, OP_U3,
      OP_WGT, OP_READ, OP_MAC, OP_DLOAD, OP_DSTEP, OP_PSTORE, OP_VSTORE,
      OP_ALOAD, OP_SCHI, OP_SCLO, OP_SRND, OP_ZERO, OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic [1:0] cls;
      logic [1:0] pnt;
   } cmd_type;

   typedef struct packed {
      logic eval_ok;
      logic rates;
   } stat_type;

endpackage

### src/cbte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbte_ctrl
// Sequencer of the evaluator: accepts transactions, steps the datapath
// through span search, basis, multiply-accumulate and scaling, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cbte_ctrl
   import cbte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_command,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  stat_type   status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] cls_ff, cls_in;
   logic [1:0] pnt_ff, pnt_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         cls_ff       <= '0;
         pnt_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cls_ff       <= cls_in;
         pnt_ff       <= pnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath command
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cls_in       = cls_ff;
      pnt_in       = pnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.axis     = axis_ff;
      cmd.cls      = cls_ff;
      cmd.pnt      = pnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (req_command == CMD_EVAL && status.eval_ok) state_in = ST_CDUR;
            end
         end
         ST_CDUR: begin
            cmd.op   = OP_CDUR;
            state_in = ST_TIME;
         end
         ST_TIME: begin
            cmd.op   = OP_TIME;
            state_in = ST_TAU;
         end
         ST_TAU: begin
            cmd.op   = OP_TAU;
            state_in = ST_SEG;
         end
         ST_SEG: begin
            cmd.op   = OP_SEG;
            state_in = ST_U2;
         end
         ST_U2: begin
            cmd.op   = OP_U2;
            state_in = ST_U3;
         end
         ST_U3: begin
            cmd.op   = OP_U3;
            state_in = ST_WGT;
         end
         ST_WGT: begin
            cmd.op   = OP_WGT;
            pnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.op   = OP_READ;
            axis_in  = '0;
            cls_in   = CLS_POS;
            state_in = ST_MAC;
         end
         // nine products per control point: axis by weight class
         ST_MAC: begin
            cmd.op = OP_MAC;
            if (cls_ff == CLS_ACC) begin
               cls_in = CLS_POS;
               if (axis_ff == 2'd2) begin
                  axis_in = '0;
                  if (pnt_ff == 2'd3) begin
                     state_in = ST_DLOAD;
                  end else begin
                     pnt_in   = pnt_ff + 2'd1;
                     state_in = ST_READ;
                  end
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               cls_in = cls_ff + 2'd1;
            end
         end
         ST_DLOAD: begin
            cmd.op   = OP_DLOAD;
            step_in  = '0;
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.op = OP_DSTEP;
            if (step_ff == 3'd4) begin
               state_in = (cls_ff == CLS_POS) ? ST_PSTORE : ST_VSTORE;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_PSTORE: begin
            cmd.op = OP_PSTORE;
            if (status.rates) begin
               cls_in   = CLS_VEL;
               state_in = ST_DLOAD;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_VSTORE: begin
            cmd.op   = OP_VSTORE;
            state_in = ST_SCHI;
         end
         ST_ALOAD: begin
            cmd.op   = OP_ALOAD;
            state_in = ST_SCHI;
         end
         ST_SCHI: begin
            cmd.op   = OP_SCHI;
            state_in = ST_SCLO;
         end
         ST_SCLO: begin
            cmd.op   = OP_SCLO;
            state_in = ST_SRND;
         end
         ST_SRND: begin
            cmd.op = OP_SRND;
            if (cls_ff == CLS_VEL) begin
               cls_in   = CLS_ACC;
               state_in = ST_ALOAD;
            end else if (axis_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               cls_in   = CLS_POS;
               state_in = ST_DLOAD;
            end
         end
         ST_ZERO: begin
            cmd.op = OP_ZERO;
            if (axis_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               cls_in   = CLS_POS;
               state_in = ST_DLOAD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### src/cbte_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbte_dpath
// Datapath of the evaluator: configuration registers, control point store,
// shared 32x32 front multiplier, weight multiply-accumulate, byte-serial
// divide by six, and the two-pass rate scaler.
// ----------------------------------------------------------------------------
module cbte_dpath
   import cbte_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output stat_type          status,
   output rsp_type           rsp_data
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = CW + 31;
   localparam int AW = 56;
   localparam int SW = 67;

   // Saturate a sign and magnitude pair to 32 bit signed
   function automatic logic [31:0] sat32(input logic neg, input logic [SW-1:0] mag);
      logic [31:0] res;
      if (!neg) begin
         res = (mag > SW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         res = (mag > SW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-mag[31:0]);
      end
      return res;
   endfunction

   // Configuration registers
   logic [30:0]        knot_ff;
   logic [22:0]        inv_ff;
   logic [29:0]        invsq_ff;
   logic [30:0]        dur_ff;
   logic               hold_ff;
   logic               usez_ff;
   logic signed [31:0] defz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knot_ff  <= 31'd16384;
         inv_ff   <= 23'd262144;
         invsq_ff <= 30'd1048576;
         dur_ff   <= '0;
         hold_ff  <= 1'b1;
         usez_ff  <= 1'b1;
         defz_ff  <= 32'sd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KNOT_SPAN:   knot_ff  <= csr_wdata[30:0];
            CSR_INV_SPAN:    inv_ff   <= csr_wdata[22:0];
            CSR_INV_SPAN_SQ: invsq_ff <= csr_wdata[29:0];
            CSR_DURATION:    dur_ff   <= csr_wdata[30:0];
            CSR_HOLD:        hold_ff  <= csr_wdata[0];
            CSR_USE_POINT_Z: usez_ff  <= csr_wdata[0];
            CSR_DEFAULT_Z:   defz_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Point count and store
   logic [CW-1:0] count_ff;
   logic [95:0]   store_mem [MAX_POINTS];
   logic [95:0]   rd_ff;
   logic          accept;
   logic          full;
   logic [IW-1:0] seg_ff, seg_in;
   logic [IW-1:0] rd_addr;

   assign accept  = (cmd.op == OP_ACCEPT);
   assign full    = (count_ff >= CW'(MAX_POINTS));
   assign rd_addr = seg_ff + IW'(cmd.pnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         if (req_data.command == CMD_CLEAR) begin
            count_ff <= '0;
         end else if (req_data.command == CMD_APPEND && !full) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.command == CMD_APPEND && !full) begin
         store_mem[count_ff[IW-1:0]] <= {req_data.point_x, req_data.point_y,
                                         usez_ff ? req_data.point_z : defz_ff};
      end
      if (cmd.op == OP_READ) rd_ff <= store_mem[rd_addr];
   end

   assign status.eval_ok = (count_ff >= CW'(4));

   // Front multiplier: duration, time scaling and powers of u
   logic [31:0]        fm_a, fm_b;
   logic [63:0]        fm_p;
   logic signed [31:0] t_ff;
   logic [DW-1:0]      cdur_ff;
   logic [30:0]        te_ff, te_in;
   logic               rates_ff, rates_in;
   logic               end_ff, end_in;
   logic [37:0]        tau_ff;
   logic [16:0]        u_ff, u_in;
   logic [16:0]        u2_ff;
   logic [16:0]        u3_ff;

   always_comb begin
      case (cmd.op)
         OP_CDUR: begin
            fm_a = 32'(count_ff - CW'(3));
            fm_b = {1'b0, knot_ff};
         end
         OP_TAU: begin
            fm_a = {1'b0, te_ff};
            fm_b = {9'd0, inv_ff};
         end
         OP_U2: begin
            fm_a = {15'd0, u_ff};
            fm_b = {15'd0, u_ff};
         end
         OP_U3: begin
            fm_a = {15'd0, u2_ff};
            fm_b = {15'd0, u_ff};
         end
         default: begin
            fm_a = '0;
            fm_b = '0;
         end
      endcase
   end

   assign fm_p = fm_a * fm_b;

   // Clamp of the evaluation time
   logic [DW-1:0] tdur;
   logic [DW-1:0] t_ext;

   always_comb begin
      tdur  = (dur_ff != '0) ? DW'(dur_ff) : cdur_ff;
      t_ext = DW'(t_ff[30:0]);
      if (!t_ff[31] && t_ext < tdur) begin
         te_in    = t_ff[30:0];
         rates_in = 1'b1;
      end else if (!t_ff[31]) begin
         te_in    = tdur[30:0];
         rates_in = !hold_ff;
      end else begin
         te_in    = '0;
         rates_in = 1'b0;
      end
      end_in = (DW'(te_in) >= cdur_ff);
   end

   // Segment and local parameter
   logic [IW-1:0] maxseg;
   logic [21:0]   sq;
   logic [37:0]   rem;

   always_comb begin
      maxseg = IW'(count_ff - CW'(4));
      sq     = tau_ff[37:16];
      rem    = tau_ff - (38'(maxseg) << 16);
      if (end_ff) begin
         seg_in = maxseg;
         u_in   = 17'h10000;
      end else if (sq > 22'(maxseg)) begin
         seg_in = maxseg;
         u_in   = (rem > 38'h10000) ? 17'h10000 : rem[16:0];
      end else begin
         seg_in = sq[IW-1:0];
         u_in   = {1'b0, tau_ff[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: t_ff    <= req_data.elapsed_time;
         OP_CDUR:   cdur_ff <= fm_p[DW-1:0];
         OP_TIME: begin
            te_ff    <= te_in;
            rates_ff <= rates_in;
            end_ff   <= end_in;
         end
         OP_TAU: tau_ff <= fm_p[53:16];
         OP_SEG: begin
            seg_ff <= seg_in;
            u_ff   <= u_in;
         end
         OP_U2:  u2_ff <= fm_p[32:16];
         OP_U3:  u3_ff <= fm_p[32:16];
         default: ;
      endcase
   end

   assign status.rates = rates_ff;

   // Basis weights in Q16: six times the position and velocity basis, and the plain acceleration basis
   logic signed [21:0] su, su2, su3, one;
   logic signed [21:0] w_ff [3][4];

   assign one = 22'sd65536;
   assign su  = signed'({5'd0, u_ff});
   assign su2 = signed'({5'd0, u2_ff});
   assign su3 = signed'({5'd0, u3_ff});

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WGT) begin
         w_ff[0][0] <= one - 22'sd3 * su + 22'sd3 * su2 - su3;
         w_ff[0][1] <= 22'sd4 * one - 22'sd6 * su2 + 22'sd3 * su3;
         w_ff[0][2] <= one + 22'sd3 * su + 22'sd3 * su2 - 22'sd3 * su3;
         w_ff[0][3] <= su3;
         w_ff[1][0] <= -22'sd3 * one + 22'sd6 * su - 22'sd3 * su2;
         w_ff[1][1] <= -22'sd12 * su + 22'sd9 * su2;
         w_ff[1][2] <= 22'sd3 * one + 22'sd6 * su - 22'sd9 * su2;
         w_ff[1][3] <= 22'sd3 * su2;
         w_ff[2][0] <= one - su;
         w_ff[2][1] <= -22'sd2 * one + 22'sd3 * su;
         w_ff[2][2] <= one - 22'sd3 * su;
         w_ff[2][3] <= su;
      end
   end

   // Weighted sums, one product per cycle, with a store read between control points
   logic signed [AW-1:0] sum_ff [3][3];
   logic signed [31:0]   coord;
   logic signed [53:0]   mac_p;
   logic signed [AW-1:0] sum_sel;

   always_comb begin
      case (cmd.axis)
         2'd0:    coord = signed'(rd_ff[95:64]);
         2'd1:    coord = signed'(rd_ff[63:32]);
         default: coord = signed'(rd_ff[31:0]);
      endcase
   end

   assign mac_p   = w_ff[cmd.cls][cmd.pnt] * coord;
   assign sum_sel = sum_ff[cmd.axis][cmd.cls];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WGT) begin
         for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) sum_ff[a][c] <= '0;
         end
      end else if (cmd.op == OP_MAC) begin
         sum_ff[cmd.axis][cmd.cls] <= sum_sel + AW'(mac_p);
      end
   end

   // Rounded divide by 6*65536: magnitude, then one byte per step
   logic                 sum_neg;
   logic [AW-1:0]        sum_mag;
   logic [AW-1:0]        div_add;
   logic [AW-1:0]        acc_add;
   logic [39:0]          div_src_ff;
   logic [39:0]          div_quo_ff;
   logic [2:0]           div_rem_ff;
   logic                 div_neg_ff;
   logic [10:0]          dx;
   logic [20:0]          dqm;
   logic [7:0]           dq;
   logic [10:0]          dr;
   logic signed [35:0]   quo_s;
   logic signed [35:0]   acc_s;

   assign sum_neg = sum_sel[AW-1];
   assign sum_mag = sum_neg ? AW'(-sum_sel) : AW'(sum_sel);
   assign div_add = sum_mag + AW'(196608);
   assign acc_add = sum_mag + AW'(32768);

   assign dx  = {div_rem_ff, div_src_ff[39:32]};
   assign dqm = 21'(dx) * 21'd683;
   assign dq  = dqm[19:12];
   assign dr  = dx - (11'({dq, 2'b00}) + 11'({dq, 1'b0}));

   assign quo_s = div_neg_ff ? -signed'(div_quo_ff[35:0]) : signed'(div_quo_ff[35:0]);
   assign acc_s = sum_neg ? -signed'(acc_add[51:16]) : signed'(acc_add[51:16]);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_DLOAD: begin
            div_src_ff <= div_add[AW-1:16];
            div_quo_ff <= '0;
            div_rem_ff <= '0;
            div_neg_ff <= sum_neg;
         end
         OP_DSTEP: begin
            div_src_ff <= {div_src_ff[31:0], 8'd0};
            div_quo_ff <= {div_quo_ff[31:0], dq};
            div_rem_ff <= dr[2:0];
         end
         default: ;
      endcase
   end

   // Rate scaler: signed operand times reciprocal, in two partial products
   logic signed [35:0]   sc_op_ff;
   logic signed [SW-1:0] sc_acc_ff;
   logic signed [18:0]   sc_x;
   logic signed [31:0]   sc_b;
   logic signed [50:0]   sc_p;
   logic                 sc_neg;
   logic [SW-1:0]        sc_mag;
   logic [SW-1:0]        sc_add;

   always_comb begin
      sc_x = (cmd.op == OP_SCHI) ? sc_op_ff[35:17] : signed'({2'b00, sc_op_ff[16:0]});
      sc_b = (cmd.cls == CLS_VEL) ? signed'({9'd0, inv_ff}) : signed'({2'd0, invsq_ff});
   end

   assign sc_p   = sc_x * sc_b;
   assign sc_neg = sc_acc_ff[SW-1];
   assign sc_mag = sc_neg ? SW'(-sc_acc_ff) : SW'(sc_acc_ff);
   assign sc_add = sc_mag + SW'(32768);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_VSTORE: sc_op_ff  <= quo_s;
         OP_ALOAD:  sc_op_ff  <= acc_s;
         OP_SCHI:   sc_acc_ff <= SW'(sc_p) <<< 17;
         OP_SCLO:   sc_acc_ff <= sc_acc_ff + SW'(sc_p);
         default: ;
      endcase
   end

   // Per-axis results and output register
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] accel_ff [3];
   rsp_type            rsp_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_PSTORE: pos_ff[cmd.axis] <= sat32(div_neg_ff, SW'(div_quo_ff));
         OP_SRND: begin
            if (cmd.cls == CLS_VEL) begin
               vel_ff[cmd.axis] <= sat32(sc_neg, SW'(sc_add[SW-1:16]));
            end else begin
               accel_ff[cmd.axis] <= sat32(sc_neg, SW'(sc_add[SW-1:16]));
            end
         end
         OP_ZERO: begin
            vel_ff[cmd.axis]   <= '0;
            accel_ff[cmd.axis] <= '0;
         end
         OP_OUT: begin
            rsp_ff.pos_x <= pos_ff[0];
            rsp_ff.pos_y <= pos_ff[1];
            rsp_ff.pos_z <= pos_ff[2];
            rsp_ff.vel_x <= vel_ff[0];
            rsp_ff.vel_y <= vel_ff[1];
            rsp_ff.vel_z <= vel_ff[2];
            rsp_ff.acc_x <= accel_ff[0];
            rsp_ff.acc_y <= accel_ff[1];
            rsp_ff.acc_z <= accel_ff[2];
         end
         default: ;
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

### src/cubic_bspline_trajectory_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_trajectory_eval_top
// Uniform cubic B-spline trajectory evaluator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Clear and append transactions produce no result. An evaluate transaction
// with four or more stored points stalls the input from acceptance until the
// result register is loaded, whether rates are produced or forced to zero.
// The evaluation time is set by the single weight multiply-accumulate unit
// (36 products, one per cycle, plus one store read per control point), the
// byte-serial divide by six (five steps per division) and the two-pass rate
// scaler. A finished result waits in its own register, so the next
// transaction can be accepted while it is still stalled at the output.
module cubic_bspline_trajectory_eval_top
   import cbte_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type status;

   // Sequencer
   cbte_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Arithmetic and storage
   cbte_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

### src/cbte_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbte_chk
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cbte_chk
   import cbte_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Clear, append and unknown commands finish in the accepting cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command != CMD_EVAL |=> !req_stall)
      else $error("input stalled after a non-evaluate transaction");

   // A new result only comes out of a busy evaluation
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an evaluation");

endmodule

bind cubic_bspline_trajectory_eval_top cbte_chk u_cbte_chk (.*);
